// ----- rtl/rbf_pkg.sv -----
// Shared constants for the byte ring FIFO with runs.
// Holds the item mode codes, status codes and fixed field widths.
// No dependencies.
package rbf_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 10;
    localparam int COUNT_W = 10;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_FILL  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

endpackage

// ----- rtl/rbf_store.sv -----
// Byte store of the ring FIFO: one write port and one registered read port.
// Depends on rbf_pkg for the byte width.
module rbf_store #(
    parameter int DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(DEPTH)-1:0]     i_waddr,
    input  logic [rbf_pkg::BYTE_W-1:0]   i_wdata,
    input  logic [$clog2(DEPTH)-1:0]     i_raddr,
    output logic [rbf_pkg::BYTE_W-1:0]   o_rdata
);

    logic [rbf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [rbf_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rbf_count.sv -----
// Occupancy arithmetic of the ring FIFO: readable and writable byte counts
// from the read and committed write indices. Depends on nothing else.
module rbf_count #(
    parameter int DEPTH = 1024
) (
    input  logic [$clog2(DEPTH)-1:0] i_read_idx,
    input  logic [$clog2(DEPTH)-1:0] i_commit_idx,
    output logic [$clog2(DEPTH)-1:0] o_readable,
    output logic [$clog2(DEPTH)-1:0] o_writable
);

    localparam int IW = $clog2(DEPTH);

    logic [IW:0] diff;
    logic [IW:0] wrapped;

    always_comb begin
        diff = {1'b0, i_commit_idx} - {1'b0, i_read_idx};
        if (diff[IW]) begin
            wrapped = diff + (IW+1)'(DEPTH);
        end else begin
            wrapped = diff;
        end
    end

    assign o_readable = wrapped[IW-1:0];
    assign o_writable = IW'(DEPTH - 1) - wrapped[IW-1:0];

endmodule

// ----- rtl/byte_ring_fifo_with_runs.sv -----
// Top level of the byte ring FIFO with write runs, fills and read runs.
// Depends on rbf_pkg, rbf_store and rbf_count.
//
// Write, read and clear items never raise busy and may be started in
// every cycle; their result is strobed on o_done in the cycle after the
// transfer. A fill of N bytes keeps busy high until its N bytes are written,
// one store write per cycle through the single write port, and its result
// follows the last write; a rejected or empty fill never raises busy. Results
// cannot be held off: each is valid only in its o_done cycle. The store needs
// no clearing pass after reset, since only committed bytes are ever read.
module byte_ring_fifo_with_runs #(
    parameter int DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic                               i_run_start,
    input  logic [rbf_pkg::LEN_W-1:0]          i_run_length,
    input  logic [rbf_pkg::BYTE_W-1:0]         i_data_byte,
    output logic                               o_done,
    output logic                               o_status,
    output logic [rbf_pkg::BYTE_W-1:0]         o_read_byte,
    output logic [rbf_pkg::COUNT_W-1:0]        o_readable_count,
    output logic [rbf_pkg::COUNT_W-1:0]        o_writable_count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = (IW > rbf_pkg::LEN_W) ? IW : rbf_pkg::LEN_W;

    typedef enum logic {
        S_IDLE,
        S_FILL
    } t_state;

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_read, n_read;
    logic [IW-1:0]               r_commit, n_commit;
    logic [IW-1:0]               r_pend, n_pend;
    logic [rbf_pkg::LEN_W-1:0]   r_remain, n_remain;
    logic                        r_is_read, n_is_read;
    logic [rbf_pkg::LEN_W-1:0]   r_fill_left, n_fill_left;
    logic                        r_done, n_done;
    logic                        r_status, n_status;
    logic                        r_rd_sel, n_rd_sel;
    logic [rbf_pkg::BYTE_W-1:0]  r_fill_data;

    logic                        accept;
    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [rbf_pkg::BYTE_W-1:0]  mem_wdata;
    logic [rbf_pkg::BYTE_W-1:0]  mem_q;
    logic [IW-1:0]               rd_cnt;
    logic [IW-1:0]               wr_cnt;
    logic                        len_over_wr;
    logic                        len_over_rd;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        if (idx == IW'(DEPTH - 1)) begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    rbf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_read),
        .o_rdata (mem_q)
    );

    rbf_count #(
        .DEPTH (DEPTH)
    ) u_count (
        .i_read_idx   (r_read),
        .i_commit_idx (r_commit),
        .o_readable   (rd_cnt),
        .o_writable   (wr_cnt)
    );

    assign busy        = (r_state == S_FILL);
    assign accept      = start && !busy;
    assign len_over_wr = CW'(i_run_length) > CW'(wr_cnt);
    assign len_over_rd = CW'(i_run_length) > CW'(rd_cnt);

    always_comb begin
        n_state     = r_state;
        n_read      = r_read;
        n_commit    = r_commit;
        n_pend      = r_pend;
        n_remain    = r_remain;
        n_is_read   = r_is_read;
        n_fill_left = r_fill_left;
        n_done      = 1'b0;
        n_status    = rbf_pkg::STATUS_OK;
        n_rd_sel    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_pend;
        mem_wdata   = i_data_byte;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        rbf_pkg::MODE_WRITE: begin
                            n_done = 1'b1;
                            if (i_run_start) begin
                                n_pend    = r_commit;
                                n_is_read = 1'b0;
                                if (len_over_wr) begin
                                    n_status = rbf_pkg::STATUS_REJECT;
                                    n_remain = '0;
                                end else begin
                                    n_remain = i_run_length;
                                end
                            end else if (r_remain == '0 || r_is_read) begin
                                n_pend    = r_commit;
                                n_remain  = '0;
                                n_is_read = 1'b0;
                                n_status  = rbf_pkg::STATUS_REJECT;
                            end
                            if (n_status == rbf_pkg::STATUS_OK && n_remain != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = n_pend;
                                n_pend    = next_idx(n_pend);
                                n_remain  = n_remain - 1'b1;
                                if (n_remain == '0) begin
                                    n_commit = n_pend;
                                end
                            end
                        end
                        rbf_pkg::MODE_FILL: begin
                            n_pend    = r_commit;
                            n_remain  = '0;
                            n_is_read = 1'b0;
                            if (len_over_wr) begin
                                n_done   = 1'b1;
                                n_status = rbf_pkg::STATUS_REJECT;
                            end else if (i_run_length == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state     = S_FILL;
                                n_fill_left = i_run_length;
                            end
                        end
                        rbf_pkg::MODE_READ: begin
                            n_done = 1'b1;
                            if (i_run_start) begin
                                n_pend    = r_commit;
                                n_remain  = '0;
                                n_is_read = 1'b0;
                                if (len_over_rd) begin
                                    n_status = rbf_pkg::STATUS_REJECT;
                                end else if (i_run_length != '0) begin
                                    n_remain  = i_run_length - 1'b1;
                                    n_is_read = 1'b1;
                                    n_read    = next_idx(r_read);
                                    n_rd_sel  = 1'b1;
                                end
                            end else if (r_remain != '0 && r_is_read) begin
                                n_remain = r_remain - 1'b1;
                                n_read   = next_idx(r_read);
                                n_rd_sel = 1'b1;
                            end else begin
                                n_pend    = r_commit;
                                n_remain  = '0;
                                n_is_read = 1'b0;
                                n_status  = rbf_pkg::STATUS_REJECT;
                            end
                        end
                        rbf_pkg::MODE_CLEAR: begin
                            n_done    = 1'b1;
                            n_read    = '0;
                            n_commit  = '0;
                            n_pend    = '0;
                            n_remain  = '0;
                            n_is_read = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                mem_we      = 1'b1;
                mem_waddr   = r_commit;
                mem_wdata   = r_fill_data;
                n_commit    = next_idx(r_commit);
                n_pend      = n_commit;
                n_fill_left = r_fill_left - 1'b1;
                if (r_fill_left == rbf_pkg::LEN_W'(1)) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_read      <= '0;
            r_commit    <= '0;
            r_pend      <= '0;
            r_remain    <= '0;
            r_is_read   <= 1'b0;
            r_fill_left <= '0;
            r_done      <= 1'b0;
            r_status    <= rbf_pkg::STATUS_OK;
            r_rd_sel    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_read      <= n_read;
            r_commit    <= n_commit;
            r_pend      <= n_pend;
            r_remain    <= n_remain;
            r_is_read   <= n_is_read;
            r_fill_left <= n_fill_left;
            r_done      <= n_done;
            r_status    <= n_status;
            r_rd_sel    <= n_rd_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fill_data <= i_data_byte;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_byte      = r_rd_sel ? mem_q : '0;
    assign o_readable_count = rbf_pkg::COUNT_W'(rd_cnt);
    assign o_writable_count = rbf_pkg::COUNT_W'(wr_cnt);

endmodule

// ----- tb/byte_ring_fifo_with_runs_test.sv -----
// Self-checking test of the byte ring FIFO with write runs, fills and read runs.
// Mirrors the FIFO state in a scoreboard and checks every strobed result.
// Depends on rbf_pkg and byte_ring_fifo_with_runs.
`timescale 1ns / 1ps

module byte_ring_fifo_with_runs_test;

    localparam int FIFO_DEPTH  = 1024;
    localparam int IDX_W       = $clog2(FIFO_DEPTH);
    localparam int ITEM_TARGET = 650;

    typedef struct {
        logic                        status;
        logic [rbf_pkg::BYTE_W-1:0]  rbyte;
        logic [rbf_pkg::COUNT_W-1:0] readable;
        logic [rbf_pkg::COUNT_W-1:0] writable;
    } t_fifo_result;

    class t_fifo_scoreboard;
        logic [rbf_pkg::BYTE_W-1:0] store [FIFO_DEPTH];
        int unsigned       rd_idx;
        int unsigned       commit_idx;
        int unsigned       pend_idx;
        int unsigned       run_left;
        bit                run_read;
        t_fifo_result      pending_results [$];
        int                errors;

        function new();
            rd_idx     = 0;
            commit_idx = 0;
            pend_idx   = 0;
            run_left   = 0;
            run_read   = 0;
            errors     = 0;
        endfunction

        function int unsigned readable_bytes();
            return (FIFO_DEPTH + commit_idx - rd_idx) % FIFO_DEPTH;
        endfunction

        function int unsigned writable_bytes();
            return (FIFO_DEPTH + rd_idx - commit_idx - 1) % FIFO_DEPTH;
        endfunction

        function void end_run();
            pend_idx = commit_idx;
            run_left = 0;
            run_read = 0;
        endfunction

        function logic [rbf_pkg::BYTE_W-1:0] pop_byte();
            logic [rbf_pkg::BYTE_W-1:0] b;
            b = store[IDX_W'(rd_idx)];
            rd_idx = (rd_idx + 1) % FIFO_DEPTH;
            run_left--;
            return b;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_item(logic [1:0] mode, logic run_start,
                                logic [rbf_pkg::LEN_W-1:0] len_in,
                                logic [rbf_pkg::BYTE_W-1:0] data);
            t_fifo_result r;
            int unsigned  len;
            len      = 32'(len_in);
            r.status = rbf_pkg::STATUS_OK;
            r.rbyte  = '0;
            case (mode)
                rbf_pkg::MODE_WRITE: begin
                    if (run_start) begin
                        end_run();
                        if (len > writable_bytes()) r.status = rbf_pkg::STATUS_REJECT;
                        else run_left = len;
                    end else if (run_left == 0 || run_read) begin
                        end_run();
                        r.status = rbf_pkg::STATUS_REJECT;
                    end
                    if (r.status == rbf_pkg::STATUS_OK && run_left > 0) begin
                        store[IDX_W'(pend_idx)] = data;
                        pend_idx = (pend_idx + 1) % FIFO_DEPTH;
                        run_left--;
                        if (run_left == 0) commit_idx = pend_idx;
                    end
                end
                rbf_pkg::MODE_FILL: begin
                    end_run();
                    if (len > writable_bytes()) begin
                        r.status = rbf_pkg::STATUS_REJECT;
                    end else begin
                        repeat (len) begin
                            store[IDX_W'(commit_idx)] = data;
                            commit_idx = (commit_idx + 1) % FIFO_DEPTH;
                        end
                        pend_idx = commit_idx;
                    end
                end
                rbf_pkg::MODE_READ: begin
                    if (run_start) begin
                        end_run();
                        if (len > readable_bytes()) begin
                            r.status = rbf_pkg::STATUS_REJECT;
                        end else if (len > 0) begin
                            run_left = len;
                            run_read = 1;
                            r.rbyte  = pop_byte();
                        end
                    end else if (run_left > 0 && run_read) begin
                        r.rbyte = pop_byte();
                    end else begin
                        end_run();
                        r.status = rbf_pkg::STATUS_REJECT;
                    end
                end
                rbf_pkg::MODE_CLEAR: begin
                    rd_idx     = 0;
                    commit_idx = 0;
                    end_run();
                end
                default: begin
                end
            endcase
            r.readable = rbf_pkg::COUNT_W'(readable_bytes());
            r.writable = rbf_pkg::COUNT_W'(writable_bytes());
            pending_results.push_back(r);
        endfunction

        function void check_result(logic status, logic [rbf_pkg::BYTE_W-1:0] rbyte,
                                   logic [rbf_pkg::COUNT_W-1:0] readable,
                                   logic [rbf_pkg::COUNT_W-1:0] writable);
            t_fifo_result e;
            if (pending_results.size() == 0) begin
                $error("result strobed with no transfer outstanding");
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                errors++;
            end
            if (rbyte !== e.rbyte) begin
                $error("read_byte: expected %0d, got %0d", e.rbyte, rbyte);
                errors++;
            end
            if (readable !== e.readable) begin
                $error("readable_count: expected %0d, got %0d", e.readable, readable);
                errors++;
            end
            if (writable !== e.writable) begin
                $error("writable_count: expected %0d, got %0d", e.writable, writable);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  i_mode;
    logic                        i_run_start;
    logic [rbf_pkg::LEN_W-1:0]   i_run_length;
    logic [rbf_pkg::BYTE_W-1:0]  i_data_byte;
    logic                        o_done;
    logic                        o_status;
    logic [rbf_pkg::BYTE_W-1:0]  o_read_byte;
    logic [rbf_pkg::COUNT_W-1:0] o_readable_count;
    logic [rbf_pkg::COUNT_W-1:0] o_writable_count;

    t_fifo_scoreboard sb;
    int             items_sent;
    int             burst_left;
    bit             steady;
    bit             drained_mid;

    byte_ring_fifo_with_runs #(.DEPTH(FIFO_DEPTH)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_run_start      (i_run_start),
        .i_run_length     (i_run_length),
        .i_data_byte      (i_data_byte),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_read_byte      (o_read_byte),
        .o_readable_count (o_readable_count),
        .o_writable_count (o_writable_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_status, o_read_byte, o_readable_count,
                                        o_writable_count);
            if (start && !busy) sb.note_item(i_mode, i_run_start, i_run_length, i_data_byte);
        end
    end

    task automatic send_item(input logic [1:0] mode, input logic run_start,
                             input logic [rbf_pkg::LEN_W-1:0] len,
                             input logic [rbf_pkg::BYTE_W-1:0] data);
        start        <= 1'b1;
        i_mode       <= mode;
        i_run_start  <= run_start;
        i_run_length <= len;
        i_data_byte  <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic pace();
        int gap;
        if (!steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_of_kind(input logic [1:0] mode, input int max_len);
        int pick;
        int len;
        int count;
        pick = $urandom_range(0, 99);
        if (pick < 5) len = 0;
        else if (pick < 12) len = $urandom_range(0, 1023);
        else len = $urandom_range(1, max_len);
        count = (len == 0) ? 1 : len;
        if (count > max_len) count = $urandom_range(1, 6);
        else if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
        for (int i = 0; i < count; i++) begin
            pace();
            send_item(mode, i == 0,
                      (i == 0) ? rbf_pkg::LEN_W'(len) : rbf_pkg::LEN_W'($urandom),
                      rbf_pkg::BYTE_W'($urandom));
        end
    endtask

    initial begin
        int pick;
        int len;
        sb           = new();
        items_sent   = 0;
        burst_left   = 0;
        steady       = 0;
        drained_mid  = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_mode       = rbf_pkg::MODE_WRITE;
        i_run_start  = 1'b0;
        i_run_length = '0;
        i_data_byte  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(rbf_pkg::MODE_READ, 1'b1, 10'd0, 8'h00);
        send_item(rbf_pkg::MODE_READ, 1'b1, 10'd1, 8'h00);
        send_item(rbf_pkg::MODE_READ, 1'b0, 10'd0, 8'h00);
        send_item(rbf_pkg::MODE_WRITE, 1'b0, 10'd0, 8'h12);
        send_item(rbf_pkg::MODE_WRITE, 1'b1, 10'd0, 8'h34);
        send_item(rbf_pkg::MODE_FILL, 1'b0, 10'd0, 8'h77);
        send_item(rbf_pkg::MODE_WRITE, 1'b1, 10'd1023, 8'h00);
        send_item(rbf_pkg::MODE_WRITE, 1'b0, 10'd0, 8'hFF);
        send_item(rbf_pkg::MODE_FILL, 1'b0, 10'd1, 8'h5A);
        send_item(rbf_pkg::MODE_FILL, 1'b1, 10'd1022, 8'hFF);
        send_item(rbf_pkg::MODE_FILL, 1'b0, 10'd1, 8'h01);
        send_item(rbf_pkg::MODE_WRITE, 1'b1, 10'd1, 8'h02);
        send_item(rbf_pkg::MODE_WRITE, 1'b0, 10'd1, 8'h03);
        send_item(rbf_pkg::MODE_READ, 1'b1, 10'd1023, 8'h00);
        send_item(rbf_pkg::MODE_READ, 1'b0, 10'd1023, 8'hFF);
        send_item(rbf_pkg::MODE_CLEAR, 1'b1, 10'd1023, 8'hFF);
        send_item(rbf_pkg::MODE_WRITE, 1'b1, 10'd4, 8'h00);
        send_item(rbf_pkg::MODE_WRITE, 1'b0, 10'd0, 8'hFF);
        send_item(rbf_pkg::MODE_WRITE, 1'b0, 10'd0, 8'hAA);
        send_item(rbf_pkg::MODE_WRITE, 1'b0, 10'd0, 8'h55);
        send_item(rbf_pkg::MODE_READ, 1'b1, 10'd4, 8'h00);
        send_item(rbf_pkg::MODE_READ, 1'b0, 10'd0, 8'h00);
        send_item(rbf_pkg::MODE_READ, 1'b0, 10'd0, 8'h00);
        send_item(rbf_pkg::MODE_READ, 1'b0, 10'd0, 8'h00);
        send_item(rbf_pkg::MODE_WRITE, 1'b1, 10'd2, 8'h11);
        send_item(rbf_pkg::MODE_READ, 1'b1, 10'd1, 8'h00);
        drain();

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 250 && !drained_mid) begin
                drain();
                drained_mid = 1;
            end
            steady = (items_sent >= 420 && items_sent < 500);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                run_of_kind(rbf_pkg::MODE_WRITE, 8);
            end else if (pick < 65) begin
                run_of_kind(rbf_pkg::MODE_READ, 6);
            end else if (pick < 85) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 40);
                pace();
                send_item(rbf_pkg::MODE_FILL, 1'($urandom), rbf_pkg::LEN_W'(len),
                          rbf_pkg::BYTE_W'($urandom));
            end else if (pick < 90) begin
                pace();
                send_item(rbf_pkg::MODE_CLEAR, 1'($urandom), rbf_pkg::LEN_W'($urandom),
                          rbf_pkg::BYTE_W'($urandom));
            end else begin
                pace();
                send_item(2'($urandom), 1'($urandom), rbf_pkg::LEN_W'($urandom),
                          rbf_pkg::BYTE_W'($urandom));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rbf_pkg.sv
rtl/rbf_store.sv
rtl/rbf_count.sv
rtl/byte_ring_fifo_with_runs.sv
tb/byte_ring_fifo_with_runs_test.sv
